FILE: sv/mmts_pkg.sv
// ----------------------------------------------------------------------------
// mmts_pkg
// Shared constants, payload types and helpers of the minute-mask task
// scheduler.
// ----------------------------------------------------------------------------
package mmts_pkg;

  localparam int MAX_TASKS       = 16;
  localparam int MASK_BYTES      = 180;
  localparam int MINUTES_PER_DAY = 24 * 60;

  localparam int SLOT_W      = 4;
  localparam int TASK_CNT_W  = 5;
  localparam int MASK_ADDR_W = $clog2(MAX_TASKS * MASK_BYTES);

  localparam logic [1:0] KIND_MASK     = 2'd0;
  localparam logic [1:0] KIND_SETTINGS = 2'd1;
  localparam logic [1:0] KIND_TICK     = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] task_slot;
    logic [7:0]        mask_byte_index;
    logic [7:0]        mask_byte;
    logic [15:0]       gap_minutes;
    logic [15:0]       run_limit;
    logic [7:0]        day_mask;
    logic [10:0]       minute_of_day;
    logic [2:0]        weekday;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] launched_task;
    logic              last;
  } launch_t;

  // per-task bookkeeping, read by the evaluator
  typedef struct packed {
    logic [15:0] last_run;
    logic [15:0] run_count;
    logic [15:0] run_limit;
    logic [15:0] gap;
    logic [7:0]  day_mask;
  } task_state_t;

  function automatic logic [MASK_ADDR_W-1:0] mask_addr(input logic [SLOT_W-1:0] slot,
                                                       input logic [7:0] byte_idx);
    return MASK_ADDR_W'(slot) * MASK_ADDR_W'(MASK_BYTES) + MASK_ADDR_W'(byte_idx);
  endfunction

endpackage

FILE: sv/mmts_channels.sv
// ----------------------------------------------------------------------------
// mmts channels
// Valid/ready channels of the scheduler: input items, launches and the
// active-task register write.
// ----------------------------------------------------------------------------
interface mmts_item_if;
  logic           valid;
  logic           ready;
  mmts_pkg::item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface mmts_launch_if;
  logic              valid;
  logic              ready;
  mmts_pkg::launch_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface mmts_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mmts_pkg::TASK_CNT_W-1:0]     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: sv/minute_mask_task_scheduler.sv
// ----------------------------------------------------------------------------
// minute_mask_task_scheduler
// Per-minute task launcher with minute masks, gap, run limit and weekday.
// ----------------------------------------------------------------------------
// Load items (mask byte, task settings) are applied as they are accepted. A
// minute tick walks the live task slots (at most 16) in order through one
// shared evaluator. For each slot the roll step applies the midnight rollover
// and reads the slot's mask byte from the mask RAM, then the eval step
// evaluates and updates. The input is ready again once the walk ends and the
// tick's final launch goes out; a stalled launch channel can hold the walk.
// A launch is held back until the next one is found, so its last flag is
// known. Mask bytes are not cleared by reset.
module minute_mask_task_scheduler (
  input logic           clk,
  input logic           rst,
  mmts_item_if.sink     item,
  mmts_launch_if.source launch,
  mmts_cfg_if.sink      cfg
);
  import mmts_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ROLL, S_EVAL, S_FLUSH} state_t;

  state_t                 state;
  logic [SLOT_W-1:0]      idx;
  logic [TASK_CNT_W-1:0]  active_tasks;
  logic [TASK_CNT_W-1:0]  n_live;
  logic                   started;
  task_state_t            tasks [MAX_TASKS];
  task_state_t            cur;

  logic [10:0]            tk_minute;
  logic [2:0]             tk_wday;
  logic                   tk_roll;
  logic                   tk_launch;
  logic                   tk_minute_ok;

  logic                   pend_valid;
  logic [SLOT_W-1:0]      pend_task;

  logic                   item_acc;
  logic                   out_free;
  logic                   fire;
  logic                   launch_ok;
  logic                   stall;
  logic                   send_mid;
  logic                   send_final;

  logic                   ram_we;
  logic [MASK_ADDR_W-1:0] ram_waddr;
  logic [MASK_ADDR_W-1:0] ram_raddr;
  logic [7:0]             ram_rdata;

  assign cfg.ready  = 1'b1;
  assign item.ready = (state == S_IDLE);
  assign item_acc   = item.valid && item.ready;
  assign out_free   = !launch.valid || launch.ready;

  assign n_live = (active_tasks > TASK_CNT_W'(MAX_TASKS)) ? TASK_CNT_W'(MAX_TASKS)
                                                          : active_tasks;
  assign cur = tasks[idx];

  assign ram_we    = item_acc && (item.data.kind == KIND_MASK)
                     && (item.data.mask_byte_index < 8'(MASK_BYTES));
  assign ram_waddr = mask_addr(item.data.task_slot, item.data.mask_byte_index);
  // out-of-day minutes never match, keep the address inside the array
  assign ram_raddr = tk_minute_ok ? mask_addr(idx, tk_minute[10:3]) : '0;

  mmts_mask_ram u_mask_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (item.data.mask_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mmts_task_eval u_eval (
    .mask_byte (ram_rdata),
    .bit_sel   (tk_minute[2:0]),
    .minute_ok (tk_minute_ok),
    .minute    (tk_minute),
    .wday      (tk_wday),
    .ts        (cur),
    .fire      (fire)
  );

  assign launch_ok = fire && tk_launch;
  // new launch found but the held one cannot move out yet
  assign stall     = launch_ok && pend_valid && !out_free;

  // beats loaded into the launch output register this cycle
  assign send_mid   = (state == S_EVAL) && !stall && launch_ok && pend_valid;
  assign send_final = (state == S_FLUSH) && pend_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      idx          <= '0;
      active_tasks <= '0;
      started      <= 1'b0;
      pend_valid   <= 1'b0;
      launch.valid <= 1'b0;
      tk_roll      <= 1'b0;
      tk_launch    <= 1'b0;
      tk_minute_ok <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        tasks[i] <= '0;
      end
    end else begin
      if (cfg.valid && cfg.ready) begin
        active_tasks <= cfg.data;
      end
      launch.valid <= send_mid || send_final || (launch.valid && !launch.ready);

      unique case (state)
        S_IDLE: begin
          if (item_acc) begin
            unique case (item.data.kind)
              KIND_SETTINGS: begin
                tasks[item.data.task_slot].gap       <= item.data.gap_minutes;
                tasks[item.data.task_slot].run_limit <= (item.data.run_limit == 16'd0)
                                                        ? 16'hFFFF : item.data.run_limit;
                tasks[item.data.task_slot].day_mask  <= item.data.day_mask;
                tasks[item.data.task_slot].run_count <= '0;
                tasks[item.data.task_slot].last_run  <= '0;
              end
              KIND_TICK: begin
                tk_minute    <= item.data.minute_of_day;
                tk_wday      <= item.data.weekday;
                tk_roll      <= (item.data.minute_of_day == 11'd0);
                tk_minute_ok <= (item.data.minute_of_day < 11'(MINUTES_PER_DAY));
                tk_launch    <= started;
                started      <= 1'b1;
                idx          <= '0;
                state        <= (n_live == '0) ? S_FLUSH : S_ROLL;
              end
              default: begin
                // mask bytes go straight to the RAM; unknown kinds are dropped
              end
            endcase
          end
        end

        S_ROLL: begin
          if (tk_roll) begin
            tasks[idx].last_run <= cur.last_run - 16'(MINUTES_PER_DAY);
            if (cur.run_limit != 16'd1) begin
              tasks[idx].run_count <= '0;
            end
          end
          state <= S_EVAL;
        end

        S_EVAL: begin
          if (!stall) begin
            if (launch_ok) begin
              tasks[idx].last_run  <= {5'b0, tk_minute};
              tasks[idx].run_count <= cur.run_count + 16'd1;
              if (pend_valid) begin
                launch.data <= '{launched_task: pend_task, last: 1'b0};
              end
              pend_task  <= idx;
              pend_valid <= 1'b1;
            end
            if ({1'b0, idx} == n_live - TASK_CNT_W'(1)) begin
              state <= S_FLUSH;
            end else begin
              idx   <= idx + SLOT_W'(1);
              state <= S_ROLL;
            end
          end
        end

        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            launch.data <= '{launched_task: pend_task, last: 1'b1};
            pend_valid  <= 1'b0;
            state       <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // nothing is held back once the block takes items again
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("held launch left over in idle");

  // the closing launch of a tick carries the last flag and ends the walk
  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH && pend_valid && out_free) |=>
      (launch.valid && launch.data.last && state == S_IDLE))
    else $error("final launch not flagged last");

  // the walk stays inside the live slots
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROLL || state == S_EVAL) |-> ({1'b0, idx} < n_live))
    else $error("slot walk out of range");

  // a slot is evaluated right after its mask read was issued
  a_roll_then_eval: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROLL) |=> (state == S_EVAL && $stable(idx)))
    else $error("evaluation out of step with mask read");

endmodule

FILE: sv/mmts_mask_ram.sv
// ----------------------------------------------------------------------------
// mmts_mask_ram
// Minute-enable mask store, one byte per word, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module mmts_mask_ram (
  input  logic                             clk,
  input  logic                             we,
  input  logic [mmts_pkg::MASK_ADDR_W-1:0] waddr,
  input  logic [7:0]                       wdata,
  input  logic [mmts_pkg::MASK_ADDR_W-1:0] raddr,
  output logic [7:0]                       rdata
);
  import mmts_pkg::*;

  logic [7:0] mem [MAX_TASKS * MASK_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/mmts_task_eval.sv
// ----------------------------------------------------------------------------
// mmts_task_eval
// Launch test of one task: mask bit, gap since last run, run limit and
// weekday. Shared by all slots, one slot per use.
// ----------------------------------------------------------------------------
module mmts_task_eval (
  input  logic                  [7:0]  mask_byte,
  input  logic                  [2:0]  bit_sel,
  input  logic                         minute_ok,
  input  logic                  [10:0] minute,
  input  logic                  [2:0]  wday,
  input  mmts_pkg::task_state_t        ts,
  output logic                         fire
);
  import mmts_pkg::*;

  logic signed [17:0] since;
  logic signed [17:0] gap_ext;
  logic               day_ok;

  // last_run is a signed minute: it goes negative after the day rollover
  assign since   = $signed({7'b0, minute}) - $signed({{2{ts.last_run[15]}}, ts.last_run});
  assign gap_ext = $signed({2'b0, ts.gap});
  assign day_ok  = (ts.day_mask == 8'd0) || ts.day_mask[wday];

  assign fire = minute_ok && mask_byte[bit_sel] && (since > gap_ext)
                && (ts.run_count < ts.run_limit) && day_ok;

endmodule

FILE: tb/minute_mask_task_scheduler_tb.sv
// ----------------------------------------------------------------------------
// minute_mask_task_scheduler_tb
// Self-checking bench for the minute-mask task scheduler. The mask bytes of
// the minutes that ticks visit are filled first. A short directed sequence
// then covers the field extremes and the corner cases. Clock-like random
// traffic follows, under several active-task counts, and a long launch
// stall ends the run. An in-bench model predicts every launch, and each
// launch beat is compared in order as it is accepted.
// ----------------------------------------------------------------------------
module minute_mask_task_scheduler_tb;
  import mmts_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 2 * MAX_TASKS + 8;
  localparam int LONG_HOLD     = 400;
  localparam int QUIET_LIMIT   = 3000;

  // minute windows that in-day ticks land in: early morning, noon, end of day
  localparam int EARLY_END = 24;
  localparam int NOON_LO   = 720;
  localparam int NOON_HI   = 728;
  localparam int LATE_LO   = 1432;

  logic clk;
  logic rst;

  mmts_item_if   item_ch();
  mmts_launch_if launch_ch();
  mmts_cfg_if    cfg_ch();

  minute_mask_task_scheduler u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .launch (launch_ch),
    .cfg    (cfg_ch)
  );

  // scheduler state as the bench sees it
  logic [7:0]            mask_mem [MAX_TASKS][MASK_BYTES];
  logic [15:0]           task_last_run [MAX_TASKS];
  logic [15:0]           task_runs [MAX_TASKS];
  logic [15:0]           task_limit [MAX_TASKS];
  logic [15:0]           task_gap [MAX_TASKS];
  logic [7:0]            task_days [MAX_TASKS];
  logic                  ticked_once;
  logic [TASK_CNT_W-1:0] live_cfg;

  launch_t expected_launches[$];
  int      mismatch_count;
  bit      idle_on;
  bit      hold_req;
  int      clock_minute;
  int      clock_wday;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    ticked_once    = 1'b0;
    live_cfg       = '0;
    mismatch_count = 0;
    idle_on        = 1'b1;
    hold_req       = 1'b0;
    clock_minute   = 0;
    clock_wday     = 1;
    for (int i = 0; i < MAX_TASKS; i++) begin
      task_last_run[i] = '0;
      task_runs[i]     = '0;
      task_limit[i]    = '0;
      task_gap[i]      = '0;
      task_days[i]     = '0;
    end
  end

  task automatic predict_launches(input item_t it);
    int      n;
    int      since;
    launch_t hits[$];
    launch_t one;
    logic [7:0] mbyte;
    case (it.kind)
      KIND_MASK: begin
        if (it.mask_byte_index < MASK_BYTES)
          mask_mem[it.task_slot][it.mask_byte_index] = it.mask_byte;
      end
      KIND_SETTINGS: begin
        task_gap[it.task_slot]      = it.gap_minutes;
        task_limit[it.task_slot]    = (it.run_limit == 16'd0) ? 16'hFFFF : it.run_limit;
        task_days[it.task_slot]     = it.day_mask;
        task_runs[it.task_slot]     = '0;
        task_last_run[it.task_slot] = '0;
      end
      KIND_TICK: begin
        n = (live_cfg > MAX_TASKS) ? MAX_TASKS : int'(live_cfg);
        // midnight: shift last runs back a day, clear counts unless limit is one
        if (it.minute_of_day == 11'd0) begin
          for (int i = 0; i < n; i++) begin
            task_last_run[i] = task_last_run[i] - 16'(MINUTES_PER_DAY);
            if (task_limit[i] != 16'd1) task_runs[i] = '0;
          end
        end
        if (!ticked_once) begin
          ticked_once = 1'b1;
        end else begin
          for (int i = 0; i < n; i++) begin
            if (it.minute_of_day >= MINUTES_PER_DAY) continue;
            mbyte = mask_mem[i][it.minute_of_day >> 3];
            if (!mbyte[it.minute_of_day[2:0]]) continue;
            since = int'(it.minute_of_day) - int'($signed(task_last_run[i]));
            if (since <= int'(task_gap[i])) continue;
            if (task_runs[i] >= task_limit[i]) continue;
            if (task_days[i] != 8'd0 && !task_days[i][it.weekday]) continue;
            task_last_run[i]  = 16'(it.minute_of_day);
            task_runs[i]      = task_runs[i] + 16'd1;
            one.launched_task = SLOT_W'(i);
            one.last          = 1'b0;
            hits.push_back(one);
          end
          if (hits.size() > 0) hits[hits.size()-1].last = 1'b1;
          foreach (hits[k]) expected_launches.push_back(hits[k]);
        end
      end
      default: begin
      end
    endcase
  endtask

  // ---- beat builders: unused fields carry random bits ----
  function automatic item_t rand_item();
    logic [95:0] r;
    r = {$urandom(), $urandom(), $urandom()};
    return r[$bits(item_t)-1:0];
  endfunction

  function automatic item_t mask_beat(input logic [3:0] slot, input logic [7:0] idx,
                                      input logic [7:0] val);
    item_t it;
    it = rand_item();
    it.kind            = KIND_MASK;
    it.task_slot       = slot;
    it.mask_byte_index = idx;
    it.mask_byte       = val;
    return it;
  endfunction

  function automatic item_t settings_beat(input logic [3:0] slot, input logic [15:0] gap,
                                          input logic [15:0] limit, input logic [7:0] days);
    item_t it;
    it = rand_item();
    it.kind        = KIND_SETTINGS;
    it.task_slot   = slot;
    it.gap_minutes = gap;
    it.run_limit   = limit;
    it.day_mask    = days;
    return it;
  endfunction

  function automatic item_t tick_beat(input logic [10:0] minute, input logic [2:0] wday);
    item_t it;
    it = rand_item();
    it.kind          = KIND_TICK;
    it.minute_of_day = minute;
    it.weekday       = wday;
    return it;
  endfunction

  // wall-clock style tick; in-day ticks stay inside the loaded windows and wrap
  // through minute 0 so midnight is hit; unless slow, a tick may also fall past the end of the day
  function automatic item_t clock_tick(input bit slow);
    int step;
    int pick;
    int m;
    pick = $urandom_range(99);
    if (!slow && pick < 8)
      return tick_beat(11'($urandom_range(MINUTES_PER_DAY, 2047)), 3'($urandom_range(0, 7)));
    step = (slow || $urandom_range(99) < 60) ? $urandom_range(1, 3) : $urandom_range(1, 400);
    m = clock_minute + step;
    if (m >= MINUTES_PER_DAY) begin
      m          = 0;
      clock_wday = (clock_wday % 7) + 1;
    end else if (m >= NOON_HI && m < LATE_LO) begin
      m = LATE_LO;
    end else if (m >= EARLY_END && m < NOON_LO) begin
      m = NOON_LO;
    end
    clock_minute = m;
    if (!slow && $urandom_range(99) < 10)
      return tick_beat(11'(clock_minute), 3'($urandom_range(0, 7)));
    return tick_beat(11'(clock_minute), 3'(clock_wday));
  endfunction

  function automatic item_t random_settings();
    logic [15:0] gap;
    logic [15:0] limit;
    int pick;
    pick = $urandom_range(99);
    gap = (pick < 70) ? 16'($urandom_range(0, 5)) :
          (pick < 90) ? 16'($urandom_range(0, 300)) : 16'($urandom_range(0, 65535));
    pick = $urandom_range(99);
    limit = (pick < 40) ? 16'd0 :
            (pick < 70) ? 16'($urandom_range(1, 3)) : 16'($urandom_range(0, 65535));
    return settings_beat(4'($urandom_range(0, 15)), gap, limit,
                         ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(0, 255)));
  endfunction

  function automatic item_t random_mask_load();
    int pick;
    logic [7:0] idx;
    pick = $urandom_range(99);
    idx = (pick < 80) ? 8'($urandom_range(0, MASK_BYTES - 1)) :
          (pick < 90) ? 8'($urandom_range(MASK_BYTES, 255)) : 8'(clock_minute >> 3);
    return mask_beat(4'($urandom_range(0, 15)), idx,
                     ($urandom_range(99) < 30) ? 8'hFF : 8'($urandom_range(0, 255)));
  endfunction

  // ---- channel drivers ----
  task automatic send_item(input item_t it);
    if (idle_on && $urandom_range(99) < 15) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    do @(posedge clk); while (!item_ch.ready);
    predict_launches(it);
  endtask

  // stop offering and let every pending launch come out, then let the walk finish
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_launches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_active_tasks(input logic [TASK_CNT_W-1:0] count);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= count;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    live_cfg = count;
  endtask

  // ---- tests ----
  // every mask byte that an in-window tick reads gets written, for every slot
  task automatic test_mask_fill();
    for (int s = 0; s < MAX_TASKS; s++) begin
      for (int b = 0; b < EARLY_END / 8; b++)
        send_item(mask_beat(4'(s), 8'(b), 8'($urandom_range(0, 255))));
      send_item(mask_beat(4'(s), 8'(NOON_LO / 8), 8'($urandom_range(0, 255))));
      send_item(mask_beat(4'(s), 8'(LATE_LO / 8), 8'($urandom_range(0, 255))));
    end
  endtask

  task automatic test_directed();
    item_t odd;
    wait_idle();
    set_active_tasks(5'd16);
    send_item(mask_beat(4'd0, 8'd0, 8'hFF));
    send_item(mask_beat(4'd1, 8'd0, 8'hFF));
    send_item(mask_beat(4'd2, 8'd0, 8'hFF));
    send_item(mask_beat(4'd15, 8'd179, 8'hFF));
    send_item(mask_beat(4'd3, 8'd180, 8'h00));          // ignored index
    send_item(mask_beat(4'd3, 8'd255, 8'h00));          // ignored index
    send_item(settings_beat(4'd0, 16'd0, 16'd0, 8'h00));      // unlimited
    send_item(settings_beat(4'd1, 16'd0, 16'd1, 8'h00));      // runs once until reloaded
    send_item(settings_beat(4'd2, 16'hFFFF, 16'hFFFF, 8'hFF)); // gap never met
    send_item(settings_beat(4'd15, 16'd0, 16'd0, 8'h01));     // weekday zero only
    send_item(tick_beat(11'd1, 3'd1));                  // first tick: nothing
    send_item(tick_beat(11'd2, 3'd7));
    send_item(tick_beat(11'd2, 3'd7));                  // zero gap since last run
    send_item(tick_beat(11'd3, 3'd7));
    send_item(tick_beat(11'd0, 3'd3));                  // midnight rollover
    send_item(tick_beat(11'd1439, 3'd0));
    send_item(tick_beat(11'd1439, 3'd1));
    send_item(tick_beat(11'd1440, 3'd2));               // minute past end of day
    send_item(tick_beat(11'd2047, 3'd4));
    odd = rand_item();
    odd.kind = KIND_UNUSED;
    send_item(odd);
    send_item(settings_beat(4'd1, 16'd0, 16'd1, 8'h00)); // reload clears count
    send_item(tick_beat(11'd4, 3'd5));
    send_item(mask_beat(4'd0, 8'd0, 8'h00));
    send_item(tick_beat(11'd5, 3'd5));
  endtask

  task automatic test_random_phase(input logic [TASK_CNT_W-1:0] count, input int n_items,
                                   input bit no_idle);
    int pick;
    item_t odd;
    wait_idle();
    set_active_tasks(count);
    idle_on = !no_idle;
    repeat (n_items) begin
      if ($urandom_range(99) < 2) wait_idle();
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_item(clock_tick(1'b0));
      end else if (pick < 80) begin
        send_item(random_settings());
      end else if (pick < 97) begin
        send_item(random_mask_load());
      end else begin
        odd = rand_item();
        odd.kind = KIND_UNUSED;
        send_item(odd);
      end
    end
    idle_on = 1'b1;
  endtask

  // launch side held off while ticks keep coming: block fills and stalls input
  task automatic test_backpressure();
    wait_idle();
    set_active_tasks(5'd16);
    for (int s = 0; s < MAX_TASKS; s++)
      send_item(settings_beat(4'(s), 16'd0, 16'd0, 8'h00));
    hold_req = 1'b1;
    repeat (24) send_item(clock_tick(1'b1));
  endtask

  // ---- launch sink ----
  initial begin : launch_sink
    int held;
    launch_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        launch_ch.ready <= 1'b0;
        for (held = 0; held < LONG_HOLD; held++) @(posedge clk);
      end else if (idle_on && $urandom_range(99) < 15) begin
        launch_ch.ready <= 1'b0;
      end else begin
        launch_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : launch_check
    launch_t want;
    if (!rst && launch_ch.valid && launch_ch.ready) begin
      if (expected_launches.size() == 0) begin
        $error("unexpected launch beat: launched_task %0d last %0d",
               launch_ch.data.launched_task, launch_ch.data.last);
        mismatch_count++;
      end else begin
        want = expected_launches.pop_front();
        if (launch_ch.data.launched_task !== want.launched_task) begin
          $error("launched_task: expected %0d, actual %0d",
                 want.launched_task, launch_ch.data.launched_task);
          mismatch_count++;
        end
        if (launch_ch.data.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, launch_ch.data.last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (launch_ch.valid && launch_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst           <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.data  <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.data   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_mask_fill();
    test_directed();
    test_random_phase(5'd31, 24, 1'b1);
    test_random_phase(5'd0, 12, 1'b0);
    test_random_phase(5'd1, 20, 1'b0);
    test_random_phase(5'($urandom_range(2, 15)), 20, 1'b0);
    test_random_phase(5'($urandom_range(17, 30)), 20, 1'b0);
    test_random_phase(5'd16, 20, 1'b0);
    test_backpressure();
    wait_idle();

    if (mismatch_count == 0 && expected_launches.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/mmts_pkg.sv
sv/mmts_channels.sv
sv/mmts_mask_ram.sv
sv/mmts_task_eval.sv
sv/minute_mask_task_scheduler.sv
tb/minute_mask_task_scheduler_tb.sv
